>>> hw/rtl/tgsr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the tile id to source rectangle block.
package tgsr_pkg;

   localparam int NUM_TILESETS  = 4;
   localparam int NUM_DESC_REGS = 4;
   localparam int MAP_DIM_BITS  = 12;
   localparam int MAP_SIZE_W    = 13;
   localparam int COUNT_W       = 3;
   localparam int ID_W          = 16;
   localparam int PIX_W         = 8;
   localparam int SET_IDX_W     = 2;
   localparam int SRC_X_W       = 16;
   localparam int SRC_Y_W       = 24;
   localparam int DEST_W        = 20;
   localparam int DPROD_W       = (MAP_DIM_BITS + PIX_W > DEST_W) ?
                                  MAP_DIM_BITS + PIX_W : DEST_W;
   localparam int SPROD_W       = ID_W + PIX_W;

   localparam int DIV_STEPS = ID_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam int RSP_FIELDS_W = SET_IDX_W + SRC_X_W + SRC_Y_W + 2 * PIX_W + 2 * DEST_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef enum logic [2:0] {
      REG_MAP_WIDTH     = 3'd0,
      REG_MAP_HEIGHT    = 3'd1,
      REG_TILESET_0     = 3'd2,
      REG_TILESET_1     = 3'd3,
      REG_TILESET_2     = 3'd4,
      REG_TILESET_3     = 3'd5,
      REG_TILESET_COUNT = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [ID_W-1:0]  pix_w;
      logic [PIX_W-1:0] tile_h;
      logic [PIX_W-1:0] tile_w;
      logic [ID_W-1:0]  last_id;
      logic [ID_W-1:0]  first_id;
   } desc_type;

   typedef struct packed {
      logic [MAP_SIZE_W-1:0]             map_width;
      logic [MAP_SIZE_W-1:0]             map_height;
      desc_type [NUM_DESC_REGS-1:0]      desc;
      logic [COUNT_W-1:0]                count;
   } cfg_type;

   // One classified tile on its way to the back end.
   typedef struct packed {
      logic [SET_IDX_W-1:0]    set_idx;
      logic [ID_W-1:0]         local_id;
      logic [ID_W-1:0]         tpr;
      logic [PIX_W-1:0]        tile_w;
      logic [PIX_W-1:0]        tile_h;
      logic [MAP_DIM_BITS-1:0] pos_x;
      logic [MAP_DIM_BITS-1:0] pos_y;
   } qent_type;

   typedef struct packed {
      logic [SET_IDX_W-1:0] set_idx;
      logic [SRC_X_W-1:0]   src_x;
      logic [SRC_Y_W-1:0]   src_y;
      logic [PIX_W-1:0]     tile_w;
      logic [PIX_W-1:0]     tile_h;
      logic [DEST_W-1:0]    dest_x;
      logic [DEST_W-1:0]    dest_y;
      logic                 bad;
   } rsp_type;

endpackage

>>> hw/rtl/tgsr_front.sv
`timescale 1ns / 1ps
// Front end: takes tile ids, tracks map position, matches tilesets, divides out tiles per row.
module tgsr_front import tgsr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [ID_W-1:0] gid,
   output logic            q_push,
   output qent_type        q_din,
   input  logic            q_full
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type              state_ff, state_in;
   logic [MAP_DIM_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   qent_type                ent_ff, ent_in;
   logic [ID_W-1:0]         quo_ff, quo_in;
   logic [PIX_W-1:0]        rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                    accept;
   logic                    found;
   logic [SET_IDX_W-1:0]    sel;
   desc_type                d;
   logic [MAP_DIM_BITS:0]   nx, ny;
   logic                    wrap_x, wrap_y;
   logic [PIX_W:0]          trial;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;

   // first descriptor in use whose range holds the id wins
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int i = NUM_TILESETS - 1; i >= 0; i--) begin
         if (i < int'(cfg.count) && gid >= cfg.desc[i].first_id &&
             gid <= cfg.desc[i].last_id) begin
            found = 1'b1;
            sel   = SET_IDX_W'(i);
         end
      end
   end

   assign d = cfg.desc[sel];

   always_comb begin
      nx       = {1'b0, pos_x_ff} + (MAP_DIM_BITS + 1)'(1);
      ny       = {1'b0, pos_y_ff} + (MAP_DIM_BITS + 1)'(1);
      wrap_x   = (32'(nx) >= 32'(cfg.map_width)) || nx[MAP_DIM_BITS];
      wrap_y   = (32'(ny) >= 32'(cfg.map_height)) || ny[MAP_DIM_BITS];
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (accept) begin
         pos_x_in = wrap_x ? '0 : nx[MAP_DIM_BITS-1:0];
         if (wrap_x) begin
            pos_y_in = wrap_y ? '0 : ny[MAP_DIM_BITS-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_push   = 1'b0;
      trial    = {rem_ff, quo_ff[ID_W-1]};
      unique case (state_ff)
         F_IDLE: begin
            if (accept && gid != '0) begin
               ent_in.pos_x = pos_x_ff;
               ent_in.pos_y = pos_y_ff;
               ent_in.tpr   = '0;
               rem_in       = '0;
               cnt_in       = '0;
               if (found) begin
                  ent_in.set_idx  = sel;
                  ent_in.local_id = gid - d.first_id;
                  ent_in.tile_w   = d.tile_w;
                  ent_in.tile_h   = d.tile_h;
               end else begin
                  // no match: zero size makes every product zero downstream
                  ent_in.set_idx  = '0;
                  ent_in.local_id = '0;
                  ent_in.tile_w   = '0;
                  ent_in.tile_h   = '0;
               end
               if (found && d.tile_w != '0) begin
                  quo_in   = d.pix_w;
                  state_in = F_DIV;
               end else begin
                  quo_in   = '0;
                  state_in = F_PUSH;
               end
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, ent_ff.tile_w}) begin
               rem_in = PIX_W'(trial - {1'b0, ent_ff.tile_w});
               quo_in = {quo_ff[ID_W-2:0], 1'b1};
            end else begin
               rem_in = trial[PIX_W-1:0];
               quo_in = {quo_ff[ID_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      q_din     = ent_ff;
      q_din.tpr = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         cnt_ff   <= cnt_in;
      end
      ent_ff <= ent_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

>>> hw/rtl/tgsr_queue.sv
`timescale 1ns / 1ps
// Short queue of classified tiles between the front and back ends.
module tgsr_queue import tgsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type din,
   output logic     full,
   input  logic     pop,
   output qent_type dout,
   output logic     empty
);

   qent_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

>>> hw/rtl/tgsr_back.sv
`timescale 1ns / 1ps
// Back end: divides the local id by tiles per row, scales and registers the result.
module tgsr_back import tgsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  qent_type q_dout,
   output logic     q_pop,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_OUT  = 3'b100
   } bstate_type;

   bstate_type           state_ff, state_in;
   qent_type             ent_ff, ent_in;
   logic [ID_W-1:0]      quo_ff, quo_in;
   logic [ID_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;
   logic [ID_W:0]        trial;
   logic                 load;
   logic [SPROD_W-1:0]   prod_sx, prod_sy;
   logic [DPROD_W-1:0]   prod_dx, prod_dy;

   assign q_pop = (state_ff == B_IDLE) && !q_empty;
   assign load  = (state_ff == B_OUT) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, quo_ff[ID_W-1]};
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               ent_in = q_dout;
               rem_in = '0;
               cnt_in = '0;
               if (q_dout.tpr != '0) begin
                  quo_in   = q_dout.local_id;
                  state_in = B_DIV;
               end else begin
                  // bad tile: zero quotient and remainder give zero source origin
                  quo_in   = '0;
                  state_in = B_OUT;
               end
            end
         end
         B_DIV: begin
            if (trial >= {1'b0, ent_ff.tpr}) begin
               rem_in = ID_W'(trial - {1'b0, ent_ff.tpr});
               quo_in = {quo_ff[ID_W-2:0], 1'b1};
            end else begin
               rem_in = trial[ID_W-1:0];
               quo_in = {quo_ff[ID_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign prod_sx = SPROD_W'(rem_ff) * SPROD_W'(ent_ff.tile_w);
   assign prod_sy = SPROD_W'(quo_ff) * SPROD_W'(ent_ff.tile_h);
   assign prod_dx = DPROD_W'(ent_ff.pos_x) * DPROD_W'(ent_ff.tile_w);
   assign prod_dy = DPROD_W'(ent_ff.pos_y) * DPROD_W'(ent_ff.tile_h);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in   = 1'b1;
         out_in.set_idx = ent_ff.set_idx;
         out_in.src_x   = prod_sx[SRC_X_W-1:0];
         out_in.src_y   = prod_sy[SRC_Y_W-1:0];
         out_in.tile_w  = ent_ff.tile_w;
         out_in.tile_h  = ent_ff.tile_h;
         out_in.dest_x  = prod_dx[DEST_W-1:0];
         out_in.dest_y  = prod_dy[DEST_W-1:0];
         out_in.bad     = (ent_ff.tpr == '0);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      ent_ff <= ent_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      out_ff <= out_in;
   end

endmodule

>>> hw/rtl/tile_gid_to_source_rect_core.sv
`timescale 1ns / 1ps
// Top level: register file, front end, tile queue and back end.
//
// Each nonblank tile id yields one source rectangle transaction; blank ids
// only advance the map position. The front end takes no new id while it runs
// its 16-step radix-2 divider for tiles per row or waits to push, and the back
// end takes no new tile while it runs its 16-step divider of the local id
// and the scaling stage; the two overlap through a two-entry queue. A blank
// id is taken when the front end is idle and leaves it idle. The result
// register lets the back end finish the next tile while a result waits.
// Registers sit at byte address 8*i.
module tile_gid_to_source_rect_core import tgsr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ID_W-1:0]        req_tdata,   // gid
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tileset_index, src_x, src_y, tile_w, tile_h, dest_x, dest_y, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]             rsp_tuser,   // bad_tile
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [MAP_SIZE_W-1:0] map_width_ff, map_height_ff;
   logic [CSR_DATA_W-1:0] desc_ff [NUM_DESC_REGS];
   logic [COUNT_W-1:0]    count_ff;
   csr_reg_type           reg_idx;
   logic                  wr_en;
   logic [1:0]            desc_sel;
   cfg_type               cfg;
   logic                  q_push, q_pop, q_full, q_empty;
   qent_type              q_din, q_dout;
   rsp_type               rsp;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign desc_sel   = 2'(3'(reg_idx) - 3'(REG_TILESET_0));

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_W'(1);
         map_height_ff <= MAP_SIZE_W'(1);
         count_ff      <= '0;
         for (int i = 0; i < NUM_DESC_REGS; i++) begin
            desc_ff[i] <= '0;
         end
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MAP_WIDTH:     map_width_ff  <= csr_pwdata[MAP_SIZE_W-1:0];
            REG_MAP_HEIGHT:    map_height_ff <= csr_pwdata[MAP_SIZE_W-1:0];
            REG_TILESET_0, REG_TILESET_1, REG_TILESET_2, REG_TILESET_3:
               desc_ff[desc_sel] <= csr_pwdata;
            REG_TILESET_COUNT: count_ff      <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAP_WIDTH:     csr_prdata = CSR_DATA_W'(map_width_ff);
         REG_MAP_HEIGHT:    csr_prdata = CSR_DATA_W'(map_height_ff);
         REG_TILESET_0, REG_TILESET_1, REG_TILESET_2, REG_TILESET_3:
            csr_prdata = desc_ff[desc_sel];
         REG_TILESET_COUNT: csr_prdata = CSR_DATA_W'(count_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.map_width  = map_width_ff;
      cfg.map_height = map_height_ff;
      cfg.count      = count_ff;
      for (int i = 0; i < NUM_DESC_REGS; i++) begin
         cfg.desc[i] = desc_type'(desc_ff[i]);
      end
   end

   tgsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .gid        (req_tdata),
      .q_push     (q_push),
      .q_din      (q_din),
      .q_full     (q_full)
   );

   tgsr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   tgsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_dout    (q_dout),
      .q_pop     (q_pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.dest_y, rsp.dest_x, rsp.tile_h, rsp.tile_w,
                       rsp.src_y, rsp.src_x, rsp.set_idx};
   assign rsp_tuser = rsp.bad;

endmodule

>>> hw/rtl/tgsr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tile id to source rectangle block, with its bind.
module tgsr_checker import tgsr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a bad tile carries no source origin
   a_bad_src_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[41:2] == '0)
      else $error("bad tile with nonzero source origin");

   // a good tile always has a nonzero tile width
   a_good_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[49:42] != '0)
      else $error("good tile with zero tile width");

   // zero tile size scales the destination to zero
   a_zero_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:42] == '0 && rsp_tdata[57:50] == '0
      |-> rsp_tdata[97:58] == '0)
      else $error("zero tile size with nonzero destination");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind tile_gid_to_source_rect_core tgsr_checker u_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tile_gid_to_source_rect_core: scoreboard class and stimulus.
import tgsr_pkg::*;

class tile_rect_scoreboard;
   logic [MAP_SIZE_W-1:0]   map_w;
   logic [MAP_SIZE_W-1:0]   map_h;
   desc_type                desc [NUM_DESC_REGS];
   logic [COUNT_W-1:0]      set_count;
   logic [MAP_DIM_BITS-1:0] pos_x;
   logic [MAP_DIM_BITS-1:0] pos_y;
   rsp_type                 expected_rects [$];
   int                      mismatches;

   function new();
      map_w      = 1;
      map_h      = 1;
      set_count  = 0;
      pos_x      = 0;
      pos_y      = 0;
      mismatches = 0;
      foreach (desc[i]) desc[i] = '0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_MAP_WIDTH:     map_w = value[MAP_SIZE_W-1:0];
         REG_MAP_HEIGHT:    map_h = value[MAP_SIZE_W-1:0];
         REG_TILESET_0, REG_TILESET_1, REG_TILESET_2, REG_TILESET_3:
            desc[idx - REG_TILESET_0] = value;
         REG_TILESET_COUNT: set_count = value[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [CSR_DATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
         REG_MAP_WIDTH:     return CSR_DATA_W'(map_w);
         REG_MAP_HEIGHT:    return CSR_DATA_W'(map_h);
         REG_TILESET_0, REG_TILESET_1, REG_TILESET_2, REG_TILESET_3:
            return desc[idx - REG_TILESET_0];
         REG_TILESET_COUNT: return CSR_DATA_W'(set_count);
         default:           return '0;
      endcase
   endfunction

   // Size zero acts as one; sizes past the counter range wrap at its top.
   function logic [MAP_DIM_BITS-1:0] bump(input logic [MAP_DIM_BITS-1:0] pos,
                                         input logic [MAP_SIZE_W-1:0] size,
                                         output bit wrapped);
      int unsigned nxt;
      nxt     = pos + 1;
      wrapped = (nxt >= size) || (nxt > (1 << MAP_DIM_BITS) - 1);
      return wrapped ? '0 : nxt[MAP_DIM_BITS-1:0];
   endfunction

   function void step_position();
      bit wx, wy;
      pos_x = bump(pos_x, map_w, wx);
      if (wx) pos_y = bump(pos_y, map_h, wy);
   endfunction

   function void note_gid(logic [ID_W-1:0] gid);
      rsp_type     r;
      desc_type    d;
      int          lim, hit;
      int unsigned tw, th, tpr, offset, prod;
      if (gid == 0) begin
         step_position();
         return;
      end
      r   = '0;
      hit = -1;
      lim = (set_count > NUM_TILESETS) ? NUM_TILESETS : set_count;
      for (int i = 0; i < lim; i++) begin
         if (hit < 0 && desc[i].first_id <= gid && gid <= desc[i].last_id) hit = i;
      end
      if (hit < 0) begin
         r.bad = 1'b1;
      end else begin
         d         = desc[hit];
         tw        = d.tile_w;
         th        = d.tile_h;
         r.set_idx = hit[SET_IDX_W-1:0];
         r.tile_w  = d.tile_w;
         r.tile_h  = d.tile_h;
         prod      = pos_x * tw;
         r.dest_x  = prod[DEST_W-1:0];
         prod      = pos_y * th;
         r.dest_y  = prod[DEST_W-1:0];
         tpr       = (tw != 0) ? d.pix_w / tw : 0;
         offset    = gid - d.first_id;
         if (tpr == 0) begin
            r.bad = 1'b1;
         end else begin
            prod    = (offset % tpr) * tw;
            r.src_x = prod[SRC_X_W-1:0];
            prod    = (offset / tpr) * th;
            r.src_y = prod[SRC_Y_W-1:0];
         end
      end
      expected_rects.push_back(r);
      step_position();
   endfunction

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // tdata from bit 0 up: index, src_x, src_y, tile_w, tile_h, dest_x, dest_y, pad
   function void check_rect(logic [RSP_TDATA_W-1:0] tdata, logic [0:0] tuser);
      rsp_type want;
      if (expected_rects.size() == 0) begin
         $display("%0t: unexpected rect, expected none, actual tdata %0h tuser %0h",
                  $time, tdata, tuser);
         mismatches++;
         return;
      end
      want = expected_rects.pop_front();
      check_field("tileset_index", want.set_idx, tdata[1:0]);
      check_field("src_x",         want.src_x,   tdata[17:2]);
      check_field("src_y",         want.src_y,   tdata[41:18]);
      check_field("tile_w",        want.tile_w,  tdata[49:42]);
      check_field("tile_h",        want.tile_h,  tdata[57:50]);
      check_field("dest_x",        want.dest_x,  tdata[77:58]);
      check_field("dest_y",        want.dest_y,  tdata[97:78]);
      check_field("pad",           0,            tdata[RSP_TDATA_W-1:RSP_FIELDS_W]);
      check_field("bad_tile",      want.bad,     tuser[0]);
   endfunction
endclass

module tb;
   localparam int         CYCLE_LIMIT   = 3_000_000;
   localparam int         SETTLE_CYCLES = 100;
   localparam int         RANDOM_ITEMS  = 1200;
   localparam logic [2:0] REG_UNUSED    = 3'd7;

   localparam logic [ID_W-1:0] RESET_IDS [3]  = '{16'd0, 16'd1, 16'hFFFF};
   localparam logic [ID_W-1:0] SPREAD_IDS [12] = '{16'd1, 16'd100, 16'd50, 16'd101,
      16'd300, 16'd301, 16'd0, 16'd1500, 16'd3000, 16'hFFFF, 16'd999, 16'd0};
   localparam logic [ID_W-1:0] WIDE_IDS [4]  = '{16'd32767, 16'd1, 16'hFFFF, 16'd32768};

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ID_W-1:0]        req_tdata;   // gid
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // tileset_index, src_x, src_y, tile_w, tile_h, dest_x, dest_y, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;   // bad_tile
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   tile_rect_scoreboard sb;
   bit                  steady;
   int                  cycles = 0;

   tile_gid_to_source_rect_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL tile_gid_to_source_rect_core");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] make_desc(int first_id, int last_id, int tw,
                                                       int th, int pw);
      desc_type d;
      d.first_id = first_id[ID_W-1:0];
      d.last_id  = last_id[ID_W-1:0];
      d.tile_w   = tw[PIX_W-1:0];
      d.tile_h   = th[PIX_W-1:0];
      d.pix_w    = pw[ID_W-1:0];
      return d;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_desc();
      desc_type d;
      int       r;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      r = $urandom_range(0, 9);
      d.first_id = (r < 6) ? ID_W'($urandom_range(1, 400)) : ID_W'($urandom);
      r = $urandom_range(0, 9);
      if (r < 7)      d.last_id = ID_W'(d.first_id + $urandom_range(0, 300));
      else if (r < 8) d.last_id = d.first_id - 16'd1;
      else            d.last_id = ID_W'($urandom);
      r = $urandom_range(0, 9);
      d.tile_w = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'hFF :
                 PIX_W'($urandom_range(1, 255));
      r = $urandom_range(0, 9);
      d.tile_h = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : PIX_W'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0)                      d.pix_w = 16'hFFFF;
      else if (r == 1 && d.tile_w > 1) d.pix_w = ID_W'($urandom_range(0, d.tile_w - 1));
      else if (r < 4)                  d.pix_w = ID_W'($urandom);
      else                             d.pix_w = ID_W'(d.tile_w * $urandom_range(1, 64));
      return d;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_map_size();
      int                    r;
      logic [MAP_SIZE_W-1:0] sz;
      r = $urandom_range(0, 99);
      if (r < 8)       sz = 0;
      else if (r < 20) sz = 1;
      else if (r < 60) sz = MAP_SIZE_W'($urandom_range(2, 8));
      else if (r < 85) sz = MAP_SIZE_W'($urandom_range(9, 40));
      else if (r < 93) begin
         case ($urandom_range(0, 3))
            0:       sz = 13'd4095;
            1:       sz = 13'd4096;
            2:       sz = 13'd4097;
            default: sz = 13'd8191;
         endcase
      end else begin
         sz = MAP_SIZE_W'($urandom_range(1, 8191));
      end
      // junk above the register width must be dropped
      if ($urandom_range(0, 4) == 0) return {$urandom, 19'($urandom), sz};
      return CSR_DATA_W'(sz);
   endfunction

   function automatic logic [ID_W-1:0] random_gid();
      desc_type d;
      int       r;
      r = $urandom_range(0, 99);
      d = sb.desc[$urandom_range(0, NUM_DESC_REGS - 1)];
      if (r < 15) return '0;
      if (r < 65) begin
         if (d.last_id >= d.first_id)
            return ID_W'(d.first_id + $urandom_range(0, d.last_id - d.first_id));
         return ID_W'($urandom);
      end
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0:       return d.first_id;
            1:       return d.last_id;
            2:       return d.first_id - 16'd1;
            default: return d.last_id + 16'd1;
         endcase
      end
      return ID_W'($urandom);
   endfunction

   task automatic csr_read(input logic [2:0] idx);
      logic [CSR_DATA_W-1:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      want = sb.reg_value(idx);
      if (csr_prdata !== want) begin
         $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                  $time, idx, want, csr_prdata);
         sb.mismatches++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx != REG_UNUSED) csr_read(idx);
   endtask

   task automatic send_gid(input logic [ID_W-1:0] gid);
      int gap;
      gap = (!steady && $urandom_range(0, 1) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= gid;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_gid(gid);
   endtask

   // Drop valid, wait for every expected rect, then let trailing blanks settle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_random();
      steady = ($urandom_range(0, 4) == 0);
      csr_write(REG_MAP_WIDTH, random_map_size());
      csr_write(REG_MAP_HEIGHT, random_map_size());
      for (int i = 0; i < NUM_DESC_REGS; i++) csr_write(3'(REG_TILESET_0 + i), random_desc());
      if ($urandom_range(0, 2) == 0)
         csr_write(REG_TILESET_COUNT, CSR_DATA_W'(NUM_TILESETS));
      else
         csr_write(REG_TILESET_COUNT, {$urandom, $urandom});
      if ($urandom_range(0, 4) == 0) csr_write(REG_UNUSED, {$urandom, $urandom});
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (!steady && $urandom_range(0, 2) == 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (idle_len() - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_rect(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int done_items;
      int n;
      sb          = new();
      steady      = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values, then ids with no tileset in use
      for (int i = REG_MAP_WIDTH; i <= REG_TILESET_COUNT; i++) csr_read(3'(i));
      foreach (RESET_IDS[i]) send_gid(RESET_IDS[i]);
      drain();

      // overlapping ranges, zero tile width, zero tiles per row, count past the limit
      csr_write(REG_MAP_WIDTH, 5);
      csr_write(REG_MAP_HEIGHT, 3);
      csr_write(REG_TILESET_0, make_desc(1, 100, 16, 16, 128));
      csr_write(REG_TILESET_1, make_desc(50, 300, 32, 8, 256));
      csr_write(REG_TILESET_2, make_desc(1000, 2000, 0, 12, 640));
      csr_write(REG_TILESET_3, make_desc(3000, 65535, 255, 255, 200));
      csr_write(REG_TILESET_COUNT, 7);
      csr_write(REG_UNUSED, '1);
      foreach (SPREAD_IDS[i]) send_gid(SPREAD_IDS[i]);
      drain();

      // widest source offsets: one tile per row and 65535 tiles per row
      csr_write(REG_MAP_WIDTH, 4097);
      csr_write(REG_MAP_HEIGHT, 2);
      csr_write(REG_TILESET_0, make_desc(1, 32767, 1, 255, 65535));
      csr_write(REG_TILESET_1, make_desc(32768, 65535, 255, 255, 255));
      csr_write(REG_TILESET_COUNT, 2);
      foreach (WIDE_IDS[i]) send_gid(WIDE_IDS[i]);
      drain();
      csr_write(REG_TILESET_COUNT, 0);
      send_gid(16'd5);
      drain();

      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         configure_random();
         n = $urandom_range(40, 200);
         for (int k = 0; k < n; k++) begin
            // occasional blank runs push the position deeper into the map
            if ($urandom_range(0, 49) == 0) repeat ($urandom_range(2, 12)) send_gid('0);
            send_gid(random_gid());
         end
         done_items += n;
         drain();
      end

      if (sb.mismatches == 0)
         $display("PASS tile_gid_to_source_rect_core");
      else
         $display("FAIL tile_gid_to_source_rect_core");
      $finish;
   end
endmodule

>>> tile_gid_to_source_rect_core.f
hw/rtl/tgsr_pkg.sv
hw/rtl/tgsr_front.sv
hw/rtl/tgsr_queue.sv
hw/rtl/tgsr_back.sv
hw/rtl/tile_gid_to_source_rect_core.sv
hw/rtl/tgsr_checker.sv
tb/tb.sv
